// ===== src/tccw_pkg.sv =====
// shared types, constants and helpers for the text console cell writer
package tccw_pkg;

  localparam int MAX_ROWS_DEF = 25;
  localparam int MAX_COLS_DEF = 80;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 8;
  localparam int WIDTH_W    = 7;
  localparam int HEIGHT_W   = 5;
  localparam int COLOR_W    = 4;
  localparam int CELL_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR  = 2'd3;

  localparam logic [WIDTH_W-1:0]  TEXT_WIDTH_RST  = 7'd80;
  localparam logic [HEIGHT_W-1:0] TEXT_HEIGHT_RST = 5'd25;
  localparam logic [COLOR_W-1:0]  FORE_COLOR_RST  = 4'd15;
  localparam logic [COLOR_W-1:0]  BACK_COLOR_RST  = 4'd0;

  typedef enum logic [2:0] {
    FN_PUT_CUR,
    FN_PUT_AT,
    FN_CLR_CELL,
    FN_CLR_ROW,
    FN_CLR_SCR,
    FN_SCROLL,
    FN_NEWLINE,
    FN_READ
  } func_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  cols;
    logic [HEIGHT_W-1:0] rows;
    logic [COLOR_W-1:0]  fore;
    logic [COLOR_W-1:0]  back;
  } geom_t;

  typedef struct packed {
    func_t             func;
    logic [CHAR_W-1:0] char_code;
    logic              ok;
  } cmd_hdr_t;

  typedef struct packed {
    logic                ok;
    logic [CELL_W-1:0]   cell_value;
    logic [HEIGHT_W-1:0] cursor_row;
    logic [WIDTH_W-1:0]  cursor_col;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PREP,
    ST_WRITE,
    ST_NL,
    ST_CLEAR,
    ST_SRC,
    ST_SDST,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } back_state_t;

  function automatic logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] ch, geom_t g);
    make_cell = {g.back, g.fore, ch};
  endfunction

endpackage

// ===== src/tccw_ram.sv =====
// generic simple dual-port ram with registered read
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tccw_fifo.sv =====
// small register queue used between the parts and at the result side
module tccw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = data_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wptr_r + 1'b1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CNTW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNTW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== src/tccw_front.sv =====
// front end: configuration registers, item intake, range checks and addressing
module tccw_front #(
  parameter int MAX_ROWS = 25,
  parameter int MAX_COLS = 80,
  parameter int CW       = 11
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [2:0]                         in_func,
  input  logic [tccw_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [tccw_pkg::POS_W-1:0]         in_row_index,
  input  logic [tccw_pkg::POS_W-1:0]         in_col_index,
  input  logic [tccw_pkg::POS_W-1:0]         in_scroll_count,
  input  logic                               init_busy_i,
  output tccw_pkg::geom_t                    geom_o,
  input  logic                               cmd_full_i,
  output logic                               cmd_push_o,
  output tccw_pkg::cmd_hdr_t                 cmd_hdr_o,
  output logic [CW-1:0]                      cmd_addr_o
);
  import tccw_pkg::*;

  localparam logic [7:0] MAX_COLS_C = 8'(MAX_COLS);
  localparam logic [6:0] MAX_ROWS_C = 7'(MAX_ROWS);

  logic [WIDTH_W-1:0]  text_width_r;
  logic [HEIGHT_W-1:0] text_height_r;
  logic [COLOR_W-1:0]  fore_color_r;
  logic [COLOR_W-1:0]  back_color_r;

  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [POS_W-1:0]    lines;
  logic [POS_W-1:0]    mul_op;
  logic [POS_W-1:0]    col_add;
  logic [14:0]         prod;
  logic [15:0]         addr_full;
  logic                row_ok, col_ok, ok;
  func_t               func;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_width_r  <= TEXT_WIDTH_RST;
      text_height_r <= TEXT_HEIGHT_RST;
      fore_color_r  <= FORE_COLOR_RST;
      back_color_r  <= BACK_COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEXT_WIDTH:  text_width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_TEXT_HEIGHT: text_height_r <= cfg_wdata[HEIGHT_W-1:0];
        CFG_FORE_COLOR:  fore_color_r  <= cfg_wdata[COLOR_W-1:0];
        CFG_BACK_COLOR:  back_color_r  <= cfg_wdata[COLOR_W-1:0];
      endcase
    end
  end

  // geometry clipped to the store size
  assign eff_w = ({1'b0, text_width_r} > MAX_COLS_C) ? MAX_COLS_C[WIDTH_W-1:0] : text_width_r;
  assign eff_h = ({2'b0, text_height_r} > MAX_ROWS_C) ? MAX_ROWS_C[HEIGHT_W-1:0]
                                                      : text_height_r;

  assign geom_o.cols = eff_w;
  assign geom_o.rows = eff_h;
  assign geom_o.fore = fore_color_r;
  assign geom_o.back = back_color_r;

  assign func    = func_t'(in_func);
  assign lines   = (in_scroll_count > {3'b0, eff_h}) ? {3'b0, eff_h} : in_scroll_count;
  assign mul_op  = (func == FN_SCROLL) ? lines : in_row_index;
  assign col_add = (func == FN_CLR_ROW || func == FN_SCROLL) ? '0 : in_col_index;
  assign prod    = {7'b0, mul_op} * {8'b0, eff_w};
  assign addr_full = {1'b0, prod} + {8'b0, col_add};

  assign row_ok = in_row_index < {3'b0, eff_h};
  assign col_ok = in_col_index < {1'b0, eff_w};

  always_comb begin
    unique case (func)
      FN_PUT_AT, FN_CLR_CELL, FN_READ: ok = row_ok & col_ok;
      FN_CLR_ROW:                      ok = row_ok;
      default:                         ok = 1'b1;
    endcase
  end

  assign in_full    = cmd_full_i | init_busy_i;
  assign cmd_push_o = in_push & ~in_full;

  assign cmd_hdr_o.func      = func;
  assign cmd_hdr_o.char_code = in_char_code;
  assign cmd_hdr_o.ok        = ok;
  assign cmd_addr_o          = CW'(addr_full);

endmodule

// ===== src/tccw_back.sv =====
// back end: command sequencer over the cell store, cursor and result build
module tccw_back #(
  parameter int MAX_ROWS = 25,
  parameter int MAX_COLS = 80,
  parameter int DEPTH    = 2000,
  parameter int AW       = 11,
  parameter int CW       = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tccw_pkg::geom_t     geom_i,
  input  logic                cmd_empty_i,
  input  tccw_pkg::cmd_hdr_t  cmd_hdr_i,
  input  logic [CW-1:0]       cmd_addr_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output tccw_pkg::res_t      res_o,
  output logic                init_busy_o
);
  import tccw_pkg::*;

  back_state_t         state_r, state_nxt;
  func_t               func_r, func_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                ok_r, ok_nxt;
  logic [CW-1:0]       addr_r, addr_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       end_r, end_nxt;
  logic [CW-1:0]       off_r, off_nxt;
  logic [CELL_W-1:0]   val_r, val_nxt;
  logic [HEIGHT_W-1:0] cur_row_r, cur_row_nxt;
  logic [WIDTH_W-1:0]  cur_col_r, cur_col_nxt;

  logic [WIDTH_W-1:0]  w;
  logic [HEIGHT_W-1:0] h;
  logic [HEIGHT_W-1:0] mop;
  logic [11:0]         mprod;
  logic [12:0]         prod_sum;
  logic [CW:0]         src;
  logic [CW-1:0]       idx_inc;
  logic [HEIGHT_W:0]   r1;
  logic [WIDTH_W-1:0]  col1;
  logic                cur_ok;

  logic                ram_we;
  logic [CW-1:0]       waddr_c;
  logic [CW-1:0]       raddr_c;
  logic [CELL_W-1:0]   ram_wdata;
  logic [CELL_W-1:0]   ram_rdata;

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_c[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (raddr_c[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign w        = geom_i.cols;
  assign h        = geom_i.rows;
  assign mop      = (state_r == ST_PREP && func_r == FN_PUT_CUR) ? cur_row_r : h;
  assign mprod    = {5'b0, w} * {7'b0, mop};
  assign prod_sum = {1'b0, mprod} + {6'b0, cur_col_r};
  assign src      = {1'b0, idx_r} + {1'b0, off_r};
  assign idx_inc  = CW'(idx_r + 1'b1);
  assign r1       = {1'b0, cur_row_r} + 6'd1;
  assign col1     = cur_col_r + 7'd1;
  assign cur_ok   = (cur_row_r < h) && (cur_col_r < w);

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    char_nxt    = char_r;
    ok_nxt      = ok_r;
    addr_nxt    = addr_r;
    idx_nxt     = idx_r;
    end_nxt     = end_r;
    off_nxt     = off_r;
    val_nxt     = val_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    ram_we      = 1'b0;
    waddr_c     = idx_r;
    raddr_c     = addr_r;
    ram_wdata   = '0;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        // zero sweep of the whole store
        ram_we = 1'b1;
        if (idx_r == CW'(DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          func_nxt  = cmd_hdr_i.func;
          char_nxt  = cmd_hdr_i.char_code;
          ok_nxt    = cmd_hdr_i.ok;
          addr_nxt  = cmd_addr_i;
          val_nxt   = '0;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        unique case (func_r)
          FN_PUT_CUR: begin
            ok_nxt    = cur_ok;
            addr_nxt  = CW'(prod_sum);
            state_nxt = cur_ok ? ST_WRITE : ST_DONE;
          end
          FN_PUT_AT, FN_CLR_CELL: begin
            state_nxt = ok_r ? ST_WRITE : ST_DONE;
          end
          FN_CLR_ROW: begin
            idx_nxt   = addr_r;
            end_nxt   = CW'(addr_r + CW'(w));
            state_nxt = ok_r ? ST_CLEAR : ST_DONE;
          end
          FN_CLR_SCR: begin
            idx_nxt   = '0;
            end_nxt   = CW'(mprod);
            state_nxt = ST_CLEAR;
          end
          FN_SCROLL: begin
            idx_nxt   = '0;
            end_nxt   = CW'(mprod);
            off_nxt   = addr_r;
            state_nxt = ST_SRC;
          end
          FN_NEWLINE: begin
            state_nxt = ST_NL;
          end
          FN_READ: begin
            state_nxt = ok_r ? ST_READ : ST_DONE;
          end
        endcase
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        waddr_c   = addr_r;
        ram_wdata = (func_r == FN_CLR_CELL) ? '0 : make_cell(char_r, geom_i);
        if (func_r == FN_PUT_CUR) begin
          if (col1 >= w) begin
            state_nxt = ST_NL;
          end else begin
            cur_col_nxt = col1;
            state_nxt   = ST_DONE;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_NL: begin
        cur_col_nxt = '0;
        if (r1 >= {1'b0, h}) begin
          // past the last row: scroll up one line, row stays
          idx_nxt   = '0;
          end_nxt   = CW'(mprod);
          off_nxt   = CW'(w);
          state_nxt = (mprod != '0) ? ST_SRC : ST_DONE;
        end else begin
          cur_row_nxt = r1[HEIGHT_W-1:0];
          state_nxt   = ST_DONE;
        end
      end
      ST_CLEAR: begin
        if (idx_r < end_r) begin
          ram_we  = 1'b1;
          idx_nxt = idx_inc;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SRC: begin
        if (idx_r >= end_r) begin
          state_nxt = ST_DONE;
        end else if (src < {1'b0, end_r}) begin
          raddr_c   = CW'(src);
          state_nxt = ST_SDST;
        end else begin
          ram_we  = 1'b1;
          idx_nxt = idx_inc;
        end
      end
      ST_SDST: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        state_nxt = ST_SRC;
      end
      ST_READ: begin
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        val_nxt   = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_push_o = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      idx_r     <= '0;
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    char_r <= char_nxt;
    ok_r   <= ok_nxt;
    addr_r <= addr_nxt;
    end_r  <= end_nxt;
    off_r  <= off_nxt;
    val_r  <= val_nxt;
  end

  assign init_busy_o      = (state_r == ST_INIT);
  assign res_o.ok         = ok_r;
  assign res_o.cell_value = val_r;
  assign res_o.cursor_row = cur_row_r;
  assign res_o.cursor_col = cur_col_r;

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (waddr_c < CW'(DEPTH)))
    else $error("store write beyond depth");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r != $past(cur_col_r)) |->
      (cur_col_r == '0 || cur_col_r == WIDTH_W'($past(cur_col_r) + 7'd1)))
    else $error("cursor column jumped");

  a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SDST) |-> ($past(state_r) == ST_SRC))
    else $error("scroll copy write without source read");

endmodule

// ===== src/text_console_cell_writer_core.sv =====
// top level of the text console cell writer: front end, command queue, back end
// the back end runs one command at a time; a put at the cursor that wraps adds a newline
// clears write one cell per cycle through the single write port of the cell store,
// while a scroll copy reads each cell before it writes it
// reset: synchronous, cursor to home, geometry 80x25, colours 15/0; a zeroing pass of
// MAX_ROWS*MAX_COLS cells follows reset during which no item is taken
module text_console_cell_writer_core #(
  parameter int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [2:0]                        in_func,
  input  logic [tccw_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [tccw_pkg::POS_W-1:0]        in_row_index,
  input  logic [tccw_pkg::POS_W-1:0]        in_col_index,
  input  logic [tccw_pkg::POS_W-1:0]        in_scroll_count,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_ok,
  output logic [tccw_pkg::CELL_W-1:0]       out_cell_value,
  output logic [tccw_pkg::HEIGHT_W-1:0]     out_cursor_row,
  output logic [tccw_pkg::WIDTH_W-1:0]      out_cursor_col
);
  import tccw_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int QDEPTH = 2;
  localparam int HDR_W  = $bits(cmd_hdr_t);
  localparam int RES_W  = $bits(res_t);

  geom_t             geom;
  logic              init_busy;
  logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_hdr_t          hdr_in, hdr_out;
  logic [CW-1:0]     addr_in, addr_out;
  logic [HDR_W+CW-1:0] cmd_q_in, cmd_q_out;
  logic              res_push, res_full;
  res_t              res_in, res_out;
  logic [RES_W-1:0]  res_q_out;

  tccw_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .CW       (CW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_char_code    (in_char_code),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_scroll_count (in_scroll_count),
    .init_busy_i     (init_busy),
    .geom_o          (geom),
    .cmd_full_i      (cmd_full),
    .cmd_push_o      (cmd_push),
    .cmd_hdr_o       (hdr_in),
    .cmd_addr_o      (addr_in)
  );

  assign cmd_q_in = {hdr_in, addr_in};

  tccw_fifo #(
    .WIDTH (HDR_W + CW),
    .DEPTH (QDEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_q_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_q_out),
    .empty (cmd_empty)
  );

  assign hdr_out  = cmd_hdr_t'(cmd_q_out[HDR_W+CW-1:CW]);
  assign addr_out = cmd_q_out[CW-1:0];

  tccw_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .DEPTH    (DEPTH),
    .AW       (AW),
    .CW       (CW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .geom_i      (geom),
    .cmd_empty_i (cmd_empty),
    .cmd_hdr_i   (hdr_out),
    .cmd_addr_i  (addr_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .init_busy_o (init_busy)
  );

  tccw_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q_out),
    .empty (out_empty)
  );

  assign res_out        = res_t'(res_q_out);
  assign out_ok         = res_out.ok;
  assign out_cell_value = res_out.cell_value;
  assign out_cursor_row = res_out.cursor_row;
  assign out_cursor_col = res_out.cursor_col;

endmodule

// ===== tb/tb_text_console_cell_writer_core.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the text console cell writer core
module tb_text_console_cell_writer_core;
  import tccw_pkg::*;

  localparam int NCELLS = MAX_ROWS_DEF * MAX_COLS_DEF;

  typedef struct {
    func_t      fn;
    logic [7:0] ch;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] cnt;
  } console_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TEXT_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  func_t                 in_func = FN_PUT_CUR;
  logic [CHAR_W-1:0]     in_char_code = '0;
  logic [POS_W-1:0]      in_row_index = '0;
  logic [POS_W-1:0]      in_col_index = '0;
  logic [POS_W-1:0]      in_scroll_count = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_ok;
  logic [CELL_W-1:0]     out_cell_value;
  logic [HEIGHT_W-1:0]   out_cursor_row;
  logic [WIDTH_W-1:0]    out_cursor_col;

  // mirror of the screen, cursor and registers
  logic [CELL_W-1:0]   screen_cells [NCELLS];
  logic [HEIGHT_W-1:0] crs_row = '0;
  logic [WIDTH_W-1:0]  crs_col = '0;
  logic [WIDTH_W-1:0]  reg_cols = TEXT_WIDTH_RST;
  logic [HEIGHT_W-1:0] reg_rows = TEXT_HEIGHT_RST;
  logic [COLOR_W-1:0]  reg_fore = FORE_COLOR_RST;
  logic [COLOR_W-1:0]  reg_back = BACK_COLOR_RST;

  console_cmd_t pending_cmds[$];
  res_t         awaited_replies[$];
  console_cmd_t next_cmd;
  console_cmd_t seen_cmd;
  res_t         got_reply;

  int     n_errors = 0;
  int     in_gap = 0;
  int     out_gap = 0;
  bit     calm = 1'b0;
  bit     in_took = 1'b0;
  longint cycle_budget = 4 * NCELLS + 10000;
  longint cycle_count = 0;

  text_console_cell_writer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_char_code    (in_char_code),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_scroll_count (in_scroll_count),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_ok          (out_ok),
    .out_cell_value  (out_cell_value),
    .out_cursor_row  (out_cursor_row),
    .out_cursor_col  (out_cursor_col)
  );

  always #5 clk = ~clk;

  function automatic int unsigned used_cols();
    return (reg_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(reg_cols);
  endfunction

  function automatic int unsigned used_rows();
    return (reg_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(reg_rows);
  endfunction

  function automatic bit on_screen(int unsigned r, int unsigned c);
    return r < used_rows() && c < used_cols();
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(logic [CHAR_W-1:0] ch);
    return {reg_back, reg_fore, ch};
  endfunction

  function automatic void blank_row(int unsigned r);
    int unsigned w = used_cols();
    if (r >= used_rows()) return;
    for (int unsigned k = 0; k < w; k++) screen_cells[w * r + k] = '0;
  endfunction

  function automatic void scroll_screen(int unsigned lines);
    int unsigned w = used_cols();
    int unsigned h = used_rows();
    int unsigned n = lines;
    if (w == 0 || h == 0) return;
    if (n > h) n = h;
    repeat (n) begin
      for (int unsigned i = 1; i < h; i++)
        for (int unsigned k = 0; k < w; k++)
          screen_cells[w * (i - 1) + k] = screen_cells[w * i + k];
      blank_row(h - 1);
    end
  endfunction

  function automatic void line_feed();
    int unsigned r = crs_row + 1;
    crs_col = '0;
    if (r >= used_rows()) begin
      scroll_screen(1);
      r--;
    end
    crs_row = HEIGHT_W'(r);
  endfunction

  function automatic res_t run_console_cmd(console_cmd_t c);
    int unsigned w = used_cols();
    int unsigned h = used_rows();
    res_t rs;
    rs.ok = 1'b1;
    rs.cell_value = '0;
    case (c.fn)
      FN_PUT_CUR: begin
        if (!on_screen(crs_row, crs_col)) begin
          rs.ok = 1'b0;
        end else begin
          screen_cells[w * crs_row + crs_col] = cell_of(c.ch);
          crs_col++;
          if (crs_col >= w) line_feed();
        end
      end
      FN_PUT_AT: begin
        if (on_screen(c.row, c.col)) screen_cells[w * c.row + c.col] = cell_of(c.ch);
        else rs.ok = 1'b0;
      end
      FN_CLR_CELL: begin
        if (on_screen(c.row, c.col)) screen_cells[w * c.row + c.col] = '0;
        else rs.ok = 1'b0;
      end
      FN_CLR_ROW: begin
        if (c.row < h) blank_row(c.row);
        else rs.ok = 1'b0;
      end
      FN_CLR_SCR: begin
        for (int unsigned i = 0; i < w * h; i++) screen_cells[i] = '0;
      end
      FN_SCROLL: scroll_screen(c.cnt);
      FN_NEWLINE: line_feed();
      FN_READ: begin
        if (on_screen(c.row, c.col)) rs.cell_value = screen_cells[w * c.row + c.col];
        else rs.ok = 1'b0;
      end
    endcase
    rs.cursor_row = crs_row;
    rs.cursor_col = crs_col;
    return rs;
  endfunction

  task automatic program_regs(logic [WIDTH_W-1:0] w, logic [HEIGHT_W-1:0] h,
                              logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TEXT_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= CFG_TEXT_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_index <= CFG_FORE_COLOR;
    cfg_wdata <= CFG_DATA_W'(fg);
    @(negedge clk);
    cfg_index <= CFG_BACK_COLOR;
    cfg_wdata <= CFG_DATA_W'(bg);
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_cols = w;
    reg_rows = h;
    reg_fore = fg;
    reg_back = bg;
  endtask

  task automatic queue_cmd(func_t fn, logic [7:0] ch, logic [7:0] row, logic [7:0] col,
                           logic [7:0] cnt);
    console_cmd_t c;
    int unsigned w, h, lines;
    w = used_cols();
    h = used_rows();
    c.fn = fn;
    c.ch = ch;
    c.row = row;
    c.col = col;
    c.cnt = cnt;
    lines = (cnt > h) ? h : cnt;
    cycle_budget += 82 + 2 * w * h * (lines + 2);
    pending_cmds.push_back(c);
  endtask

  function automatic logic [7:0] pick_pos(int unsigned lim);
    case ($urandom_range(0, 9))
      0, 1: return 8'($urandom_range(0, 255));
      2: return 8'(lim);
      default: return (lim == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, lim - 1));
    endcase
  endfunction

  task automatic queue_random(int n);
    int unsigned w, h, r;
    int unsigned lim [7];
    func_t fn;
    logic [7:0] cnt;
    w = used_cols();
    h = used_rows();
    // large screens make scroll and clear expensive, so keep them rare
    if (w * h > 400) lim = '{30, 50, 58, 62, 63, 64, 69};
    else lim = '{22, 38, 46, 53, 57, 65, 75};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < lim[0]) fn = FN_PUT_CUR;
      else if (r < lim[1]) fn = FN_PUT_AT;
      else if (r < lim[2]) fn = FN_CLR_CELL;
      else if (r < lim[3]) fn = FN_CLR_ROW;
      else if (r < lim[4]) fn = FN_CLR_SCR;
      else if (r < lim[5]) fn = FN_SCROLL;
      else if (r < lim[6]) fn = FN_NEWLINE;
      else fn = FN_READ;
      if (w * h > 400) begin
        cnt = 8'($urandom_range(0, 2));
      end else begin
        case ($urandom_range(0, 2))
          0: cnt = 8'($urandom_range(0, 3));
          1: cnt = 8'((h == 0) ? $urandom_range(0, 1) : h - 1 + $urandom_range(0, 2));
          default: cnt = 8'($urandom_range(0, 255));
        endcase
      end
      queue_cmd(fn, 8'($urandom_range(0, 255)), pick_pos(h), pick_pos(w), cnt);
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_push || awaited_replies.size() != 0);
    @(negedge clk);
  endtask

  task automatic report(string what, int unsigned want, int unsigned seen);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
    n_errors++;
  endtask

  // item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_push <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        in_func <= next_cmd.fn;
        in_char_code <= next_cmd.ch;
        in_row_index <= next_cmd.row;
        in_col_index <= next_cmd.col;
        in_scroll_count <= next_cmd.cnt;
        in_push <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 11);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_pop <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if ($urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 11);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_took <= in_push && !in_full;
    if (rst_n && in_push && !in_full) begin
      seen_cmd.fn = in_func;
      seen_cmd.ch = in_char_code;
      seen_cmd.row = in_row_index;
      seen_cmd.col = in_col_index;
      seen_cmd.cnt = in_scroll_count;
      awaited_replies.push_back(run_console_cmd(seen_cmd));
    end
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: result with none expected, actual ok %0b cell %0h row %0d col %0d",
                 $time, out_ok, out_cell_value, out_cursor_row, out_cursor_col);
        n_errors++;
      end else begin
        got_reply = awaited_replies.pop_front();
        if (out_ok !== got_reply.ok) report("ok", got_reply.ok, out_ok);
        if (out_cell_value !== got_reply.cell_value)
          report("cell_value", got_reply.cell_value, out_cell_value);
        if (out_cursor_row !== got_reply.cursor_row)
          report("cursor_row", got_reply.cursor_row, out_cursor_row);
        if (out_cursor_col !== got_reply.cursor_col)
          report("cursor_col", got_reply.cursor_col, out_cursor_col);
      end
    end
  end

  initial begin
    while (cycle_count < 4 * cycle_budget) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < NCELLS; i++) screen_cells[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (in_full);

    // zero geometry
    program_regs(7'd0, 5'd0, 4'd15, 4'd0);
    queue_cmd(FN_PUT_CUR, 8'h41, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_PUT_AT, 8'h42, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_CLR_CELL, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_CLR_ROW, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_CLR_SCR, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_SCROLL, 8'h00, 8'd0, 8'd0, 8'd1);
    queue_cmd(FN_NEWLINE, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_READ, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_random(40);
    drain();

    // single cell screen: every write at the cursor wraps and scrolls
    program_regs(7'd1, 5'd1, 4'd0, 4'd15);
    queue_cmd(FN_PUT_CUR, 8'hff, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_PUT_AT, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_READ, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_READ, 8'h00, 8'd0, 8'd1, 8'd0);
    queue_cmd(FN_READ, 8'h00, 8'd1, 8'd0, 8'd0);
    queue_cmd(FN_PUT_AT, 8'haa, 8'd255, 8'd255, 8'd255);
    queue_cmd(FN_PUT_AT, 8'h80, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_SCROLL, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_READ, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_SCROLL, 8'h00, 8'd0, 8'd0, 8'd255);
    queue_cmd(FN_READ, 8'h00, 8'd0, 8'd0, 8'd0);
    queue_cmd(FN_CLR_ROW, 8'h00, 8'd1, 8'd0, 8'd0);
    queue_cmd(FN_CLR_CELL, 8'h00, 8'd0, 8'd255, 8'd0);
    queue_random(100);
    drain();

    program_regs(7'd0, 5'd3, COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
    queue_random(40);
    drain();
    program_regs(7'd6, 5'd3, COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
    queue_random(250);
    drain();
    program_regs(7'd80, 5'd4, COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
    queue_random(150);
    drain();
    program_regs(7'd3, 5'd8, COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
    queue_random(200);
    drain();
    program_regs(7'd13, 5'd12, COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
    queue_random(250);
    drain();

    // oversized geometry is clamped to the full store
    program_regs(7'd127, 5'd31, 4'd0, 4'd15);
    queue_cmd(FN_PUT_AT, 8'h7e, 8'd24, 8'd79, 8'd0);
    queue_cmd(FN_READ, 8'h00, 8'd24, 8'd79, 8'd0);
    queue_cmd(FN_READ, 8'h00, 8'd25, 8'd0, 8'd0);
    queue_cmd(FN_READ, 8'h00, 8'd0, 8'd80, 8'd0);
    queue_random(160);
    drain();

    // shrink below the cursor, no idling from here on
    calm = 1'b1;
    program_regs(7'd10, 5'd5, COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
    queue_random(350);
    drain();
    repeat (300) @(posedge clk);

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
